[rtl/prf_pkg.sv]
// ----------------------------------------------------------------------------
// prf_pkg
// Shared types and constants of the partial register file: access kinds,
// configuration register indexes, lane decode constants and field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package prf_pkg;

	// default number of register slots
	localparam int REG_SLOTS_DEF = 64;

	// payload widths
	localparam int KIND_W  = 3;
	localparam int INDEX_W = 32;
	localparam int VALUE_W = 64;
	localparam int FMASK_W = 32;
	localparam int SLOT_W  = 16;
	localparam int FSLOT_W = 6;

	// configuration port widths
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 8;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MODE_64    = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FLAGS_SLOT = 4'd1;

	// upper half of the index that names the low-32 lane (width 32, offset 0)
	localparam logic [15:0] LOW32_LANE = 16'h0020;

	localparam logic [VALUE_W-1:0] ALL_ONES   = {VALUE_W{1'b1}};
	localparam logic [VALUE_W-1:0] LOW32_MASK = {32'd0, 32'hFFFF_FFFF};

	// access kinds
	typedef enum logic [KIND_W-1:0] {
		KIND_READ_REG    = 3'd0,
		KIND_WRITE_REG   = 3'd1,
		KIND_TEST_FLAG   = 3'd2,
		KIND_WRITE_FLAG  = 3'd3,
		KIND_READ_TAINT  = 3'd4,
		KIND_WRITE_TAINT = 3'd5
	} kind_t;

endpackage

`default_nettype wire

[rtl/prf_cmd_if.sv]
// ----------------------------------------------------------------------------
// prf_cmd_if
// Access channel of the partial register file: valid/ready and one access item.
// ----------------------------------------------------------------------------
`default_nettype none

interface prf_cmd_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [31:0] reg_index;
	logic [63:0] write_value;
	logic [31:0] flag_mask;
	logic        bit_value;

	modport source (output valid, kind, reg_index, write_value, flag_mask, bit_value,
		input ready);
	modport sink (input valid, kind, reg_index, write_value, flag_mask, bit_value,
		output ready);
endinterface

`default_nettype wire

[rtl/prf_rsp_if.sv]
// ----------------------------------------------------------------------------
// prf_rsp_if
// Result channel of the partial register file: valid/ready and one result item.
// ----------------------------------------------------------------------------
`default_nettype none

interface prf_rsp_if;
	logic        valid;
	logic        ready;
	logic [63:0] read_value;
	logic        bit_out;

	modport source (output valid, read_value, bit_out, input ready);
	modport sink (input valid, read_value, bit_out, output ready);
endinterface

`default_nettype wire

[rtl/prf_cfg_if.sv]
// ----------------------------------------------------------------------------
// prf_cfg_if
// Configuration write channel: valid/ready, register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface prf_cfg_if;
	logic       valid;
	logic       ready;
	logic [3:0] index;
	logic [7:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/partial_register_file.sv]
// Flow: an item goes through stage 1 into the result register, where rsp takes it.
// Throughput: one item per cycle while the result channel does not stall, set by
//   the single read-modify-write pass over the register memory (read at acceptance,
//   write back as the item leaves stage 1).
// Reset: control clears at once; a clearing pass then zeroes the register memory
//   slot by slot while cmd.ready stays low (config writes are still taken).
// ----------------------------------------------------------------------------
// partial_register_file
// Emulated register file with lane reads and writes, flag operations on a
// configured flags slot, and a taint mark per register.
// ----------------------------------------------------------------------------
`default_nettype none

module partial_register_file #(
	parameter int REG_SLOTS = prf_pkg::REG_SLOTS_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	prf_cfg_if.sink    cfg,
	prf_cmd_if.sink    cmd,
	prf_rsp_if.source  rsp
);
	import prf_pkg::*;

	localparam int AW      = (REG_SLOTS > 1) ? $clog2(REG_SLOTS) : 1;
	localparam int ENTRY_W = VALUE_W + 1;

	// configuration registers
	logic               mode_64_q;
	logic [FSLOT_W-1:0] flags_slot_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_64_q    <= 1'b0;
			flags_slot_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_MODE_64:    mode_64_q    <= cfg.data[0];
				CFG_FLAGS_SLOT: flags_slot_q <= cfg.data[FSLOT_W-1:0];
				default: ;
			endcase
		end
	end

	// clearing pass after reset
	logic          clr_busy_q;
	logic [AW-1:0] clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			if (clr_addr_q == AW'(REG_SLOTS - 1)) begin
				clr_busy_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	// pipeline handshake
	logic valid_s1;
	logic out_valid_q;
	logic adv;
	logic accept;

	assign adv       = !out_valid_q || rsp.ready;
	assign cmd.ready = !clr_busy_q && (!valid_s1 || adv);
	assign accept    = cmd.valid && cmd.ready;

	// read address decode at acceptance
	kind_t             cmd_kind;
	logic              cmd_is_flag;
	logic [SLOT_W-1:0] sel_slot;
	logic              flags_ok;
	logic              slot_ok;
	logic [AW-1:0]     raddr;

	assign cmd_kind    = kind_t'(cmd.kind);
	assign cmd_is_flag = (cmd_kind == KIND_TEST_FLAG) || (cmd_kind == KIND_WRITE_FLAG);
	assign flags_ok    = {26'd0, flags_slot_q} < 32'(REG_SLOTS);
	assign slot_ok     = {16'd0, cmd.reg_index[SLOT_W-1:0]} < 32'(REG_SLOTS);
	assign sel_slot    = cmd_is_flag ? {10'd0, flags_slot_q} : cmd.reg_index[SLOT_W-1:0];
	assign raddr       = sel_slot[AW-1:0];

	// stage 1 registers
	kind_t              kind_s1;
	logic [INDEX_W-1:0] idx_s1;
	logic [VALUE_W-1:0] wval_s1;
	logic [FMASK_W-1:0] fmask_s1;
	logic               bit_s1;
	logic               hit_s1;
	logic [AW-1:0]      addr_s1;
	logic [ENTRY_W-1:0] entry_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// stage 1 computation
	logic [15:0]        upper;
	logic [7:0]         off;
	logic [7:0]         wid;
	logic               far;
	logic               lane32;
	logic [VALUE_W-1:0] old_val;
	logic [VALUE_W-1:0] wmask;
	logic [VALUE_W-1:0] lane;
	logic [VALUE_W-1:0] bits;
	logic [VALUE_W-1:0] smask;
	logic [VALUE_W-1:0] fm;
	logic [VALUE_W-1:0] new_val;
	logic               new_taint;
	logic               s1_we;
	logic [VALUE_W-1:0] rv;
	logic               bo;

	assign upper   = idx_s1[31:16];
	assign off     = idx_s1[31:24];
	assign wid     = idx_s1[23:16];
	assign far     = off[7:6] != 2'd0;
	assign lane32  = mode_64_q && (upper == LOW32_LANE);
	assign old_val = entry_s1[VALUE_W-1:0];
	assign wmask   = (wid[7:6] != 2'd0) ? ALL_ONES : ~(ALL_ONES << wid[5:0]);
	assign lane    = far ? '0 : (wmask << off[5:0]);
	assign bits    = far ? '0 : ((wval_s1 << off[5:0]) & lane);
	assign smask   = mode_64_q ? ALL_ONES : LOW32_MASK;
	assign fm      = {32'd0, fmask_s1};

	always_comb begin
		new_val   = old_val;
		new_taint = entry_s1[VALUE_W];
		s1_we     = 1'b0;
		rv        = '0;
		bo        = 1'b0;
		case (kind_s1)
			KIND_READ_REG: begin
				if (hit_s1) begin
					if (upper == 16'd0) begin
						rv = old_val;
					end else if (!far) begin
						rv = (old_val >> off[5:0]) & wmask;
					end
				end
			end
			KIND_WRITE_REG: begin
				s1_we = hit_s1;
				if (upper == 16'd0 || lane32) begin
					new_val = wval_s1 & smask;
				end else begin
					new_val = ((old_val & ~lane) | bits) & smask;
				end
			end
			KIND_TEST_FLAG: begin
				bo = hit_s1 && ((old_val & fm) != '0);
			end
			KIND_WRITE_FLAG: begin
				s1_we   = hit_s1;
				new_val = bit_s1 ? (old_val | fm) : (old_val & ~fm);
			end
			KIND_READ_TAINT: begin
				bo = hit_s1 && entry_s1[VALUE_W];
			end
			KIND_WRITE_TAINT: begin
				s1_we     = hit_s1;
				new_taint = bit_s1;
			end
			default: ;
		endcase
	end

	// memory write port: clearing pass or write-back of the leaving item
	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic [ENTRY_W-1:0] mem_wdata;
	logic               wb_we;

	assign wb_we     = valid_s1 && adv && s1_we;
	assign mem_we    = clr_busy_q || wb_we;
	assign mem_waddr = clr_busy_q ? clr_addr_q : addr_s1;
	assign mem_wdata = clr_busy_q ? '0 : {new_taint, new_val};

	// register memory, one entry holds {taint, value}
	logic [ENTRY_W-1:0] mem_q [REG_SLOTS];

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
	end

	// capture item and read data, forwarding a same-cycle write-back
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1  <= cmd_kind;
			idx_s1   <= cmd.reg_index;
			wval_s1  <= cmd.write_value;
			fmask_s1 <= cmd.flag_mask;
			bit_s1   <= cmd.bit_value;
			hit_s1   <= cmd_is_flag ? flags_ok : slot_ok;
			addr_s1  <= raddr;
			if (wb_we && (addr_s1 == raddr)) begin
				entry_s1 <= mem_wdata;
			end else begin
				entry_s1 <= mem_q[raddr];
			end
		end
	end

	// result register
	logic [VALUE_W-1:0] read_value_q;
	logic               bit_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			read_value_q <= rv;
			bit_out_q    <= bo;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.read_value = read_value_q;
	assign rsp.bit_out    = bit_out_q;

endmodule

`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the partial register file. A directed pass covers
// whole and lane accesses, zero extension, masking, far offsets, slots out of
// range, flag and taint operations and the unused kinds. Random passes follow
// under changing modes and flag slots with idle and stall patterns on both
// channels. Each result is compared with a local image of the registers.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
	import prf_pkg::*;

	localparam int REG_SLOTS   = REG_SLOTS_DEF;
	localparam int CYCLE_LIMIT = 200_000;
	localparam int RAND_PASSES = 8;
	localparam int PASS_ITEMS  = 94;

	// kinds outside the enum: the block must ignore them
	localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd6;
	localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd7;

	// first configuration index with no register behind it
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = CFG_FLAGS_SLOT + 1'b1;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [INDEX_W-1:0] reg_index;
		logic [VALUE_W-1:0] write_value;
		logic [FMASK_W-1:0] flag_mask;
		logic               bit_value;
	} access_t;

	typedef struct packed {
		logic [VALUE_W-1:0] read_value;
		logic               bit_out;
	} result_t;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	logic clk;
	logic arst_n;

	prf_cfg_if cfg_ch ();
	prf_cmd_if cmd_ch ();
	prf_rsp_if rsp_ch ();

	partial_register_file #(.REG_SLOTS(REG_SLOTS)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch)
	);

	// image of the block state
	logic [VALUE_W-1:0] reg_image [REG_SLOTS] = '{default: '0};
	logic               taint_image [REG_SLOTS] = '{default: 1'b0};
	logic               mode_image;
	logic [FSLOT_W-1:0] flags_image;

	access_t access_queue [$];
	result_t result_queue [$];
	access_t cur_access;
	logic [INDEX_W-1:0] recent_write_index;

	int send_idle_pct;
	int stall_pct;
	int error_count = 0;
	int cycle_count = 0;

	// clock
	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [VALUE_W-1:0] width_ones(input logic [7:0] wid);
		return (wid >= 8'd64) ? ALL_ONES : ((64'd1 << wid) - 64'd1);
	endfunction

	function automatic logic [VALUE_W-1:0] shift_up(input logic [VALUE_W-1:0] v,
		input logic [7:0] n);
		return (n >= 8'd64) ? '0 : (v << n);
	endfunction

	function automatic logic [VALUE_W-1:0] shift_down(input logic [VALUE_W-1:0] v,
		input logic [7:0] n);
		return (n >= 8'd64) ? '0 : (v >> n);
	endfunction

	function automatic logic [INDEX_W-1:0] lane_index(input logic [15:0] slot,
		input logic [7:0] wid, input logic [7:0] off);
		return {off, wid, slot};
	endfunction

	function automatic access_t make_access(input logic [KIND_W-1:0] kind,
		input logic [INDEX_W-1:0] idx, input logic [VALUE_W-1:0] value,
		input logic [FMASK_W-1:0] fmask, input logic bitv);
		access_t acc;
		acc.kind        = kind;
		acc.reg_index   = idx;
		acc.write_value = value;
		acc.flag_mask   = fmask;
		acc.bit_value   = bitv;
		return acc;
	endfunction

	// apply one access to the image and return the result it gives
	function automatic result_t apply_access(input access_t acc);
		result_t res;
		logic [15:0] slot;
		logic [15:0] upper;
		logic [VALUE_W-1:0] lane;
		logic [VALUE_W-1:0] keep;
		logic [VALUE_W-1:0] fword;
		res   = '0;
		slot  = acc.reg_index[15:0];
		upper = acc.reg_index[31:16];
		keep  = mode_image ? ALL_ONES : LOW32_MASK;
		fword = {32'd0, acc.flag_mask};
		case (acc.kind)
			KIND_READ_REG: begin
				if (slot < REG_SLOTS) begin
					res.read_value = reg_image[slot];
					if (upper != '0)
						res.read_value = shift_down(reg_image[slot], upper[15:8]) &
							width_ones(upper[7:0]);
				end
			end
			KIND_WRITE_REG: begin
				// low-32 lane in 64-bit mode is a plain whole-register store
				if (mode_image && upper == LOW32_LANE)
					upper = '0;
				if (slot < REG_SLOTS) begin
					if (upper != '0) begin
						lane = shift_up(width_ones(upper[7:0]), upper[15:8]);
						reg_image[slot] = ((reg_image[slot] & ~lane) |
							(shift_up(acc.write_value, upper[15:8]) & lane)) & keep;
					end else begin
						reg_image[slot] = acc.write_value & keep;
					end
				end
			end
			KIND_TEST_FLAG: begin
				if (flags_image < REG_SLOTS)
					res.bit_out = |(reg_image[flags_image] & fword);
			end
			KIND_WRITE_FLAG: begin
				if (flags_image < REG_SLOTS) begin
					if (acc.bit_value)
						reg_image[flags_image] = reg_image[flags_image] | fword;
					else
						reg_image[flags_image] = reg_image[flags_image] & ~fword;
				end
			end
			KIND_READ_TAINT: begin
				if (slot < REG_SLOTS)
					res.bit_out = taint_image[slot];
			end
			KIND_WRITE_TAINT: begin
				if (slot < REG_SLOTS)
					taint_image[slot] = acc.bit_value;
			end
			default: begin
			end
		endcase
		return res;
	endfunction

	// random access biased toward few slots, x86-like lanes and read-back
	function automatic access_t random_access();
		access_t acc;
		int r;
		logic [15:0] slot;
		logic [7:0] wid;
		logic [7:0] off;
		acc.write_value = {$urandom, $urandom};
		r = $urandom_range(0, 9);
		if (r == 0)
			acc.write_value = '0;
		else if (r == 1)
			acc.write_value = ALL_ONES;
		acc.flag_mask = ($urandom_range(0, 99) < 40) ? (32'd1 << $urandom_range(0, 31))
			: $urandom;
		acc.bit_value = 1'($urandom_range(0, 1));

		r = $urandom_range(0, 99);
		if (r < 55)
			slot = 16'($urandom_range(0, 7));
		else if (r < 70)
			slot = 16'(flags_image);
		else if (r < 92)
			slot = 16'($urandom_range(0, REG_SLOTS - 1));
		else
			slot = 16'($urandom_range(REG_SLOTS, 16'hFFFF));

		r = $urandom_range(0, 99);
		if (r < 35) begin
			wid = 8'd0;
			off = 8'd0;
		end else if (r < 50) begin
			{off, wid} = LOW32_LANE;
		end else if (r < 80) begin
			wid = 8'd8 << $urandom_range(0, 2);
			case ($urandom_range(0, 3))
				0: off = 8'd0;
				1: off = 8'd8;
				2: off = 8'd16;
				default: off = 8'd32;
			endcase
		end else begin
			wid = 8'($urandom);
			off = 8'($urandom);
		end
		acc.reg_index = lane_index(slot, wid, off);

		r = $urandom_range(0, 99);
		if (r < 24) begin
			acc.kind = KIND_READ_REG;
			if ($urandom_range(0, 99) < 30)
				acc.reg_index = recent_write_index;
		end else if (r < 48) begin
			acc.kind = KIND_WRITE_REG;
			recent_write_index = acc.reg_index;
		end else if (r < 60) begin
			acc.kind = KIND_TEST_FLAG;
		end else if (r < 72) begin
			acc.kind = KIND_WRITE_FLAG;
		end else if (r < 83) begin
			acc.kind = KIND_READ_TAINT;
		end else if (r < 94) begin
			acc.kind = KIND_WRITE_TAINT;
		end else begin
			acc.kind = (r < 97) ? KIND_SPARE_A : KIND_SPARE_B;
		end
		return acc;
	endfunction

	task automatic set_idling(input idle_mode_t mode);
		case (mode)
			IDLE_SENDER:   begin send_idle_pct = 87; stall_pct = 0;  end
			IDLE_RECEIVER: begin send_idle_pct = 0;  stall_pct = 87; end
			IDLE_BOTH:     begin send_idle_pct = 31; stall_pct = 31; end
			default:       begin send_idle_pct = 0;  stall_pct = 0;  end
		endcase
	endtask

	// one configuration write, held until taken
	task automatic write_config(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		cfg_ch.valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		if (idx == CFG_MODE_64)
			mode_image = data[0];
		else if (idx == CFG_FLAGS_SLOT)
			flags_image = data[FSLOT_W-1:0];
		cfg_ch.valid <= 1'b0;
	endtask

	// write both registers with noise in the unused data bits, plus an unused index
	task automatic configure(input logic mode, input logic [FSLOT_W-1:0] fslot);
		logic [CFG_DATA_W-1:0] noise;
		noise = CFG_DATA_W'($urandom);
		write_config(CFG_MODE_64, {noise[7:1], mode});
		noise = CFG_DATA_W'($urandom);
		write_config(CFG_FLAGS_SLOT, {noise[7:6], fslot});
		noise = CFG_DATA_W'($urandom);
		write_config(CFG_IDX_W'($urandom_range(CFG_FIRST_UNUSED, 15)), noise);
	endtask

	task automatic drain();
		while (access_queue.size() != 0 || cmd_ch.valid || result_queue.size() != 0)
			@(posedge clk);
	endtask

	// access driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd_ch.valid && cmd_ch.ready)
				result_queue.push_back(apply_access(cur_access));
			if (!cmd_ch.valid || cmd_ch.ready) begin
				if (access_queue.size() != 0 &&
					$urandom_range(0, 99) >= send_idle_pct) begin
					cur_access = access_queue.pop_front();
					cmd_ch.kind        <= cur_access.kind;
					cmd_ch.reg_index   <= cur_access.reg_index;
					cmd_ch.write_value <= cur_access.write_value;
					cmd_ch.flag_mask   <= cur_access.flag_mask;
					cmd_ch.bit_value   <= cur_access.bit_value;
					cmd_ch.valid       <= 1'b1;
				end else begin
					cmd_ch.valid <= 1'b0;
				end
			end
		end else begin
			cmd_ch.valid       <= 1'b0;
			cmd_ch.kind        <= KIND_READ_REG;
			cmd_ch.reg_index   <= '0;
			cmd_ch.write_value <= '0;
			cmd_ch.flag_mask   <= '0;
			cmd_ch.bit_value   <= 1'b0;
		end
	end

	// result monitor and receiver stalls
	always @(posedge clk) begin : result_monitor
		result_t want;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (result_queue.size() == 0) begin
					$error("result with no access outstanding: read_value %h bit_out %b",
						rsp_ch.read_value, rsp_ch.bit_out);
					error_count++;
				end else begin
					want = result_queue.pop_front();
					if (rsp_ch.read_value !== want.read_value) begin
						$error("read_value mismatch: expected %h, got %h",
							want.read_value, rsp_ch.read_value);
						error_count++;
					end
					if (rsp_ch.bit_out !== want.bit_out) begin
						$error("bit_out mismatch: expected %b, got %b",
							want.bit_out, rsp_ch.bit_out);
						error_count++;
					end
				end
			end
			rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
		end else begin
			rsp_ch.ready <= 1'b0;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// stimulus sequence
	initial begin : sequencer
		logic mode;
		logic [FSLOT_W-1:0] fslot;
		cfg_ch.valid       <= 1'b0;
		cfg_ch.index       <= CFG_MODE_64;
		cfg_ch.data        <= '0;
		arst_n = 1'b0;
		recent_write_index = '0;
		mode_image = 1'b0;
		flags_image = '0;
		set_idling(IDLE_NONE);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed, 64-bit mode with flags in slot 0
		configure(1'b1, 6'd0);
		access_queue.push_back(make_access(KIND_WRITE_REG, 32'd0, ALL_ONES, '0, 1'b0));
		// clearing touches only the low half of the flags word
		access_queue.push_back(make_access(KIND_WRITE_FLAG, '0, '0, 32'hFFFF_FFFF, 1'b0));
		access_queue.push_back(make_access(KIND_READ_REG, 32'd0, '0, '0, 1'b0));
		access_queue.push_back(make_access(KIND_TEST_FLAG, '0, '0, 32'hFFFF_FFFF, 1'b0));
		access_queue.push_back(make_access(KIND_WRITE_FLAG, '0, '0, 32'h0000_0001, 1'b1));
		access_queue.push_back(make_access(KIND_TEST_FLAG, '0, '0, 32'd0, 1'b0));
		access_queue.push_back(make_access(KIND_TEST_FLAG, '0, '0, 32'h8000_0001, 1'b0));
		// low-32 lane store in 64-bit mode writes the whole register
		access_queue.push_back(make_access(KIND_WRITE_REG, lane_index(16'd1, 8'd32, 8'd0),
			64'hDEAD_BEEF_1234_5678, '0, 1'b0));
		access_queue.push_back(make_access(KIND_READ_REG, lane_index(16'd1, 8'd8, 8'd8),
			'0, '0, 1'b0));
		access_queue.push_back(make_access(KIND_WRITE_REG, lane_index(16'd1, 8'd8, 8'd8),
			64'hFFFF_FFFF_FFFF_FFAB, '0, 1'b0));
		// wide lane and far offset
		access_queue.push_back(make_access(KIND_READ_REG, lane_index(16'd1, 8'd255, 8'd0),
			'0, '0, 1'b0));
		access_queue.push_back(make_access(KIND_READ_REG, lane_index(16'd1, 8'd8, 8'd255),
			'0, '0, 1'b0));
		access_queue.push_back(make_access(KIND_WRITE_REG, lane_index(16'd1, 8'd64, 8'd64),
			ALL_ONES, '0, 1'b0));
		access_queue.push_back(make_access(KIND_READ_REG, 32'd1, '0, '0, 1'b0));
		// slot out of range
		access_queue.push_back(make_access(KIND_WRITE_REG, 32'hFFFF_FFFF, ALL_ONES, '0, 1'b1));
		access_queue.push_back(make_access(KIND_READ_REG, 32'hFFFF_FFFF, '0, '0, 1'b0));
		access_queue.push_back(make_access(KIND_WRITE_TAINT, INDEX_W'(REG_SLOTS),
			'0, '0, 1'b1));
		access_queue.push_back(make_access(KIND_READ_TAINT, INDEX_W'(REG_SLOTS),
			'0, '0, 1'b0));
		access_queue.push_back(make_access(KIND_WRITE_TAINT, INDEX_W'(REG_SLOTS - 1),
			'0, '0, 1'b1));
		access_queue.push_back(make_access(KIND_READ_TAINT, INDEX_W'(REG_SLOTS - 1),
			'0, '0, 1'b0));
		// unused kinds
		access_queue.push_back(make_access(KIND_SPARE_A, 32'd1, ALL_ONES, 32'hFFFF_FFFF, 1'b1));
		access_queue.push_back(make_access(KIND_SPARE_B, 32'd0, ALL_ONES, 32'hFFFF_FFFF, 1'b1));
		drain();

		// directed, 32-bit mode with flags in the top slot
		configure(1'b0, 6'd63);
		access_queue.push_back(make_access(KIND_WRITE_REG, 32'd2, ALL_ONES, '0, 1'b0));
		access_queue.push_back(make_access(KIND_WRITE_REG, lane_index(16'd2, 8'd16, 8'd24),
			64'h0000_0000_0000_5A5A, '0, 1'b0));
		access_queue.push_back(make_access(KIND_WRITE_REG, lane_index(16'd2, 8'd8, 8'd200),
			ALL_ONES, '0, 1'b0));
		access_queue.push_back(make_access(KIND_WRITE_FLAG, '0, '0, 32'hFFFF_FFFF, 1'b1));
		access_queue.push_back(make_access(KIND_READ_REG, 32'd63, '0, '0, 1'b0));
		drain();

		// random passes over idle patterns and settings
		for (int p = 0; p < RAND_PASSES; p++) begin
			case (p)
				0: begin mode = 1'b0; fslot = 6'd0;  end
				1: begin mode = 1'b1; fslot = 6'd63; end
				2: begin mode = 1'b1; fslot = 6'd0;  end
				3: begin mode = 1'b0; fslot = 6'd63; end
				default: begin
					mode  = 1'($urandom_range(0, 1));
					fslot = FSLOT_W'($urandom);
				end
			endcase
			configure(mode, fslot);
			set_idling(idle_mode_t'(p % 4));
			for (int i = 0; i < PASS_ITEMS; i++)
				access_queue.push_back(random_access());
			drain();
		end

		repeat (8) @(posedge clk);
		if (error_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

`default_nettype wire

[partial_register_file.f]
rtl/prf_pkg.sv
rtl/prf_cmd_if.sv
rtl/prf_rsp_if.sv
rtl/prf_cfg_if.sv
rtl/partial_register_file.sv
tb/tb_top.sv
